### rtl/tksi_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package tksi_pkg;

  localparam int RANK_W  = 4;
  localparam int TAG_W   = 32;
  localparam int SCORE_W = 32;
  localparam int LEVEL_W = 16;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_PROBE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  typedef struct packed {
    logic [TAG_W-1:0]   tag;
    logic [SCORE_W-1:0] score;
    logic [LEVEL_W-1:0] level;
  } tksi_entry_t;

  // single write port into the table
  typedef struct packed {
    logic              en;
    logic [RANK_W-1:0] addr;
    tksi_entry_t       data;
  } tksi_wr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SHIFT,
    ST_WRITE,
    ST_DONE
  } tksi_state_t;

endpackage

`default_nettype wire

### rtl/tksi_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface tksi_in_if;
  import tksi_pkg::*;
  logic               valid;
  logic               ready;
  logic [1:0]         opcode;
  logic [TAG_W-1:0]   tag_chars;
  logic [SCORE_W-1:0] new_score;
  logic [LEVEL_W-1:0] new_level;
  logic [RANK_W-1:0]  read_index;

  modport source (output valid, opcode, tag_chars, new_score, new_level, read_index,
                  input ready);
  modport sink   (input valid, opcode, tag_chars, new_score, new_level, read_index,
                  output ready);
endinterface

interface tksi_out_if;
  import tksi_pkg::*;
  logic               valid;
  logic               ready;
  logic               qualifies;
  logic [RANK_W-1:0]  rank;
  logic [TAG_W-1:0]   entry_tag;
  logic [SCORE_W-1:0] entry_score;
  logic [LEVEL_W-1:0] entry_level;

  modport source (output valid, qualifies, rank, entry_tag, entry_score, entry_level,
                  input ready);
  modport sink   (input valid, qualifies, rank, entry_tag, entry_score, entry_level,
                  output ready);
endinterface

`default_nettype wire

### rtl/tksi_table.sv
`timescale 1ns / 1ps
`default_nettype none

module tksi_table
  import tksi_pkg::*;
#(
  parameter int TABLE_DEPTH = 10
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  input  wire logic [$clog2(TABLE_DEPTH)-1:0]     rd_addr,
  output tksi_entry_t                             rd_data,
  input  tksi_wr_t                                wr
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  tksi_entry_t entry_r [TABLE_DEPTH];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
        entry_r[i] <= '0;
      end
    end else if (wr.en) begin
      entry_r[wr.addr[IDX_W-1:0]] <= wr.data;
    end
  end

  assign rd_data = entry_r[rd_addr];

endmodule

`default_nettype wire

### rtl/tksi_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module tksi_ctrl
  import tksi_pkg::*;
#(
  parameter int TABLE_DEPTH = 10
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  tksi_in_if.sink                             in_ch,
  tksi_out_if.source                          out_ch,
  output logic [$clog2(TABLE_DEPTH)-1:0]      rd_addr,
  input  tksi_entry_t                         rd_data,
  output tksi_wr_t                            wr
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam logic [IDX_W-1:0]  LAST      = IDX_W'(TABLE_DEPTH - 1);
  localparam logic [RANK_W:0]   DEPTH_EXT = (RANK_W + 1)'(TABLE_DEPTH);

  tksi_state_t state_r, state_nxt;

  logic [1:0]         op_r;
  logic [TAG_W-1:0]   tag_r;
  logic [SCORE_W-1:0] score_r;
  logic [LEVEL_W-1:0] level_r;
  logic [RANK_W-1:0]  idx_r;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  logic [IDX_W-1:0]   pos_r, pos_nxt;
  logic               hit_r, hit_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic               out_q_r;
  logic [RANK_W-1:0]  out_rank_r;
  tksi_entry_t        out_entry_r;

  logic               accept;
  logic               load_out;
  logic               score_le;
  logic               idx_ok;

  assign accept   = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (state_r == ST_IDLE);
  // the one shared comparator
  assign score_le = (rd_data.score <= score_r);
  assign idx_ok   = ({1'b0, idx_r} < DEPTH_EXT);
  assign load_out = (state_r == ST_DONE) && (!out_valid_r || out_ch.ready);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    pos_nxt   = pos_r;
    hit_nxt   = hit_r;
    rd_addr   = cnt_r;
    wr.en     = 1'b0;
    wr.addr   = RANK_W'(cnt_r);
    wr.data   = rd_data;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          cnt_nxt = '0;
          pos_nxt = '0;
          hit_nxt = 1'b0;
          if (in_ch.opcode == OP_INSERT || in_ch.opcode == OP_PROBE) begin
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (score_le) begin
          hit_nxt = 1'b1;
          pos_nxt = cnt_r;
          if (op_r != OP_INSERT) begin
            state_nxt = ST_DONE;
          end else if (cnt_r == LAST) begin
            state_nxt = ST_WRITE;
          end else begin
            cnt_nxt   = LAST;
            state_nxt = ST_SHIFT;
          end
        end else if (cnt_r == LAST) begin
          state_nxt = ST_DONE;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_SHIFT: begin
        // move entry cnt-1 down into cnt, walking toward the insert rank
        rd_addr = cnt_r - 1'b1;
        wr.en   = 1'b1;
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r - 1'b1 == pos_r) begin
          state_nxt = ST_WRITE;
        end
      end
      ST_WRITE: begin
        wr.en        = 1'b1;
        wr.addr      = RANK_W'(pos_r);
        wr.data.tag   = tag_r;
        wr.data.score = score_r;
        wr.data.level = level_r;
        state_nxt    = ST_DONE;
      end
      ST_DONE: begin
        rd_addr = idx_r[IDX_W-1:0];
        if (load_out) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      pos_r       <= '0;
      hit_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      cnt_r       <= cnt_nxt;
      pos_r       <= pos_nxt;
      hit_r       <= hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= in_ch.opcode;
      tag_r   <= in_ch.tag_chars;
      score_r <= in_ch.new_score;
      level_r <= in_ch.new_level;
      idx_r   <= in_ch.read_index;
    end
    if (load_out) begin
      out_q_r    <= hit_r;
      out_rank_r <= hit_r ? RANK_W'(pos_r) : '0;
      out_entry_r <= (op_r == OP_READ && idx_ok) ? rd_data : '0;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.qualifies   = out_q_r;
  assign out_ch.rank        = out_rank_r;
  assign out_ch.entry_tag   = out_entry_r.tag;
  assign out_ch.entry_score = out_entry_r.score;
  assign out_ch.entry_level = out_entry_r.level;

endmodule

`default_nettype wire

### rtl/top_k_sorted_insert_table_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Top-k score table, kept sorted by descending score (ties: newest first).
// in_ch carries one request: opcode (insert / probe / read), tag, score,
// level and read index. out_ch returns exactly one result per request.
// Both channels use valid/ready; a request is taken when both are high.
// Requests are handled one at a time by a small sequencer around a single
// score comparator and a one-read, one-write entry table:
//   read   : goes straight to the done state, then returns the entry
//   probe  : scans from rank 0 up to the first qualifying rank, or to the end
//   insert : when stored, scans to the rank, then shifts the tail one entry
//            per cycle and writes the new entry; rejected when none qualifies
// The sequencer is idle again in the cycle the result turns valid.
// in_ch.ready is high only while the sequencer is idle. The result sits in an
// output register, so the next request is accepted while a result waits; a
// stalled receiver holds the sequencer only when a second result is done.
// Reset (synchronous, rst_n low) clears every table entry to zero and drops
// any pending result.
module top_k_sorted_insert_table_core
  import tksi_pkg::*;
#(
  parameter int TABLE_DEPTH = 10
) (
  input wire logic    clk,
  input wire logic    rst_n,
  tksi_in_if.sink     in_ch,
  tksi_out_if.source  out_ch
);

  localparam int IDX_W = $clog2(TABLE_DEPTH);

  logic [IDX_W-1:0] rd_addr;
  tksi_entry_t      rd_data;
  tksi_wr_t         wr;

  tksi_ctrl #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  tksi_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk     (clk),
    .rst_n   (rst_n),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  // one request in flight: never ready right after taking one
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.valid && in_ch.ready |=> !in_ch.ready)
    else $error("request accepted while busy");

  a_rank_needs_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && !out_ch.qualifies |-> out_ch.rank == '0)
    else $error("rank set without qualifying");

  a_hit_no_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid && out_ch.qualifies |->
      out_ch.entry_tag == '0 && out_ch.entry_score == '0 && out_ch.entry_level == '0)
    else $error("entry data on insert or probe result");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    in_ch.ready |-> !wr.en)
    else $error("table written while idle");

endmodule

`default_nettype wire
